[src/mqfa_pkg.sv]
// Shared types and constants for the mixed-format fixed-point ALU.
package mqfa_pkg;

    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 5;
    localparam int NUM_W   = 63;          // magnitude of the widest dividend
    localparam int CELLS   = NUM_W;       // one quotient bit per cell
    localparam int IN_W    = 80;
    localparam int OUT_W   = 48;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CMP  = 3'd4,
        OP_I2F  = 3'd5,
        OP_F2I  = 3'd6,
        OP_NONE = 3'd7
    } t_op;

    typedef struct packed {
        logic                valid;
        logic                is_div;
        logic [WORD_W-1:0]   res;
        logic [FRAC_W-1:0]   frac;
        logic                lt;
        logic                eq;
        logic                gt;
        logic                dz;
        logic                neg;
        logic [WORD_W:0]     rem;
        logic [NUM_W-1:0]    num;
        logic [WORD_W-1:0]   den;
        logic [WORD_W-1:0]   quo;
    } t_cell;

endpackage

[src/mqfa_prep.sv]
// Input register, multiplier and per-operation result logic feeding the divider chain.
module mqfa_prep (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [2:0]                  i_op,
    input  logic [mqfa_pkg::WORD_W-1:0] i_a,
    input  logic [mqfa_pkg::FRAC_W-1:0] i_af,
    input  logic [mqfa_pkg::WORD_W-1:0] i_b,
    input  logic [mqfa_pkg::FRAC_W-1:0] i_bf,
    output mqfa_pkg::t_cell             o_cell
);
    logic                        r_valid;
    logic [2:0]                  r_op;
    logic signed [31:0]          r_a;
    logic signed [31:0]          r_b;
    logic [4:0]                  r_af;
    logic [4:0]                  r_bf;
    logic signed [63:0]          r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_op   <= i_op;
            r_a    <= i_a;
            r_b    <= i_b;
            r_af   <= i_af;
            r_bf   <= i_bf;
            r_prod <= $signed(i_a) * $signed(i_b);
        end
    end

    logic signed [31:0] b_al;
    logic signed [63:0] prod_sh;
    logic signed [63:0] num64;
    logic [63:0]        num_mag;
    logic [31:0]        den_mag;
    logic [31:0]        sum;
    logic [31:0]        dif;

    always_comb begin
        if (r_af > r_bf) begin
            b_al = r_b <<< (r_af - r_bf);
        end else if (r_af < r_bf) begin
            b_al = r_b >>> (r_bf - r_af);
        end else begin
            b_al = r_b;
        end
        prod_sh = r_prod >>> r_bf;
        num64   = {{32{r_a[31]}}, r_a} <<< r_bf;
        num_mag = num64[63] ? (~num64 + 64'd1) : num64;
        den_mag = r_b[31] ? (~r_b + 32'd1) : r_b;
        sum     = r_a + b_al;
        dif     = r_a - b_al;

        o_cell        = '0;
        o_cell.valid  = r_valid;
        o_cell.frac   = r_af;
        o_cell.num    = num_mag[mqfa_pkg::NUM_W-1:0];
        o_cell.den    = den_mag;
        o_cell.neg    = r_a[31] ^ r_b[31];
        case (r_op)
            mqfa_pkg::OP_ADD: o_cell.res = sum;
            mqfa_pkg::OP_SUB: o_cell.res = dif;
            mqfa_pkg::OP_MUL: o_cell.res = prod_sh[31:0];
            mqfa_pkg::OP_DIV: begin
                o_cell.dz     = (r_b == 32'sd0);
                o_cell.is_div = (r_b != 32'sd0);
            end
            mqfa_pkg::OP_CMP: begin
                o_cell.lt = (r_a < b_al);
                o_cell.eq = (r_a == b_al);
                o_cell.gt = (r_a > b_al);
            end
            mqfa_pkg::OP_I2F: o_cell.res = r_a <<< r_af;
            mqfa_pkg::OP_F2I: begin
                o_cell.res  = r_a >>> r_af;
                o_cell.frac = '0;
            end
            default: o_cell.res = '0;
        endcase
    end
endmodule

[src/mqfa_div_cell.sv]
// One restoring-division step; the row of these cells forms the divide pipeline.
module mqfa_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  mqfa_pkg::t_cell i_cell,
    output mqfa_pkg::t_cell o_cell
);
    mqfa_pkg::t_cell         r_cell;
    mqfa_pkg::t_cell         n_cell;
    logic [mqfa_pkg::WORD_W:0]   rem_sh;
    logic [mqfa_pkg::WORD_W+1:0] diff;

    always_comb begin
        n_cell = i_cell;
        rem_sh = {i_cell.rem[mqfa_pkg::WORD_W-1:0], i_cell.num[mqfa_pkg::NUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, i_cell.den};
        // keep the remainder when the divisor does not fit
        n_cell.rem = diff[mqfa_pkg::WORD_W+1] ? rem_sh : diff[mqfa_pkg::WORD_W:0];
        n_cell.quo = {i_cell.quo[mqfa_pkg::WORD_W-2:0], ~diff[mqfa_pkg::WORD_W+1]};
        n_cell.num = {i_cell.num[mqfa_pkg::NUM_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell[$bits(mqfa_pkg::t_cell)-2:0] <= n_cell[$bits(mqfa_pkg::t_cell)-2:0];
        end
    end

    assign o_cell = r_cell;
endmodule

[src/mixed_q_fixed_point_alu.sv]
// Top level of the mixed-format fixed-point ALU: input stage, divider cell row, output.
// Accepts one operation per cycle unless the output stalls; each result passes through one input
// register stage plus 63 division cells, one quotient bit per cell. Every operation,
// not only divide, travels through the cell row, so results leave in request order.
// The whole pipeline holds while a result waits at the output and i_m_tready is low.
module mixed_q_fixed_point_alu (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // a_value[31:0], a_frac[36:32], b_value[68:37], b_frac[73:69], zero fill
    input  logic [mqfa_pkg::IN_W-1:0]    i_s_tdata,
    // req_type[2:0]
    input  logic [2:0]                   i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // result_value[31:0], result_frac[36:32], less_flag[37], equal_flag[38],
    // greater_flag[39], div_zero_flag[40], zero fill
    output logic [mqfa_pkg::OUT_W-1:0]   o_m_tdata
);
    logic            en;
    mqfa_pkg::t_cell w_cell [0:mqfa_pkg::CELLS];
    mqfa_pkg::t_cell last;
    logic [31:0]     res;

    assign en         = !last.valid || i_m_tready;
    assign o_s_tready = en;

    mqfa_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_op    (i_s_tuser),
        .i_a     (i_s_tdata[31:0]),
        .i_af    (i_s_tdata[36:32]),
        .i_b     (i_s_tdata[68:37]),
        .i_bf    (i_s_tdata[73:69]),
        .o_cell  (w_cell[0])
    );

    for (genvar k = 0; k < mqfa_pkg::CELLS; k++) begin : g_cell
        mqfa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_cell  (w_cell[k]),
            .o_cell  (w_cell[k+1])
        );
    end

    assign last = w_cell[mqfa_pkg::CELLS];

    always_comb begin
        if (last.is_div) begin
            res = last.neg ? (~last.quo + 32'd1) : last.quo;
        end else begin
            res = last.res;
        end
    end

    assign o_m_tvalid = last.valid;
    assign o_m_tdata  = {7'd0, last.dz, last.gt, last.eq, last.lt, last.frac, res};

    a_flags_onehot0 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $onehot0({last.lt, last.eq, last.gt, last.dz}))
        else $error("more than one result flag set");
    a_dz_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && last.dz) |-> (res == 32'd0))
        else $error("divide by zero gave nonzero result");
    a_div_not_dz : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(last.is_div && last.dz))
        else $error("divide marked both valid and zero divisor");
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");
endmodule
